>>> rtl/scr_pkg.sv
// Shared types, constants and elaboration-time tables for the sky coordinate rotation.
package scr_pkg;

  localparam int ANGLE_BITS    = 32;
  localparam int CORDIC_STAGES = 32;
  localparam int SHIFT         = 64 - ANGLE_BITS;
  localparam int SHIFT_W       = $clog2(CORDIC_STAGES);
  localparam int FRAC          = 30;
  localparam int XW            = 36;
  localparam int IG_W          = 32;

  localparam logic [63:0] QUARTER = 64'h4000_0000_0000_0000;
  localparam logic [63:0] HALF    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] PI_Q60  = 64'h3243_F6A8_885A_308D;
  localparam logic signed [XW-1:0] ONE = XW'(64'd1 << FRAC);

  typedef logic [63:0] atan_arr_t [CORDIC_STAGES];

  typedef struct packed {
    logic                 op;
    logic                 pole;
    logic                 north;
    logic [63:0]          off;
    logic [63:0]          aux_a;
    logic signed [XW-1:0] aux_v;
  } side_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [63:0]          z;
    side_t                side;
  } vec_t;

  typedef struct packed {
    logic                         at_pole;
    logic [ANGLE_BITS-1:0]        out_lon;
    logic signed [ANGLE_BITS-1:0] out_lat;
  } res_t;

  // bitwise long division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int j = 63; j >= 0; j--) begin
      r = {r[63:0], a[j]};
      if (r >= {1'b0, b}) begin
        r    = r - {1'b0, b};
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  // n/d of a turn in 2^64 units, rounded to nearest
  function automatic logic [63:0] turn_frac(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = {1'b0, n};
    q = '0;
    for (int j = 0; j < 64; j++) begin
      r = r << 1;
      q = q << 1;
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[0] = 1'b1;
      end
    end
    if ((r << 1) >= {1'b0, d}) q = q + 64'd1;
    return q;
  endfunction

  function automatic atan_arr_t build_atan();
    atan_arr_t   t;
    logic [63:0] rad;
    logic [63:0] r;
    logic [63:0] q;
    logic [63:0] term;
    int          e;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (i == 0) begin
        t[i] = 64'd1 << 61;
      end else begin
        rad = '0;
        for (int k = 0; k < 32; k++) begin
          e = 62 - i * (2 * k + 1);
          if (e >= 0) begin
            term = udiv64(64'd1 << e, 64'(2 * k + 1));
            if ((k % 2) == 1) rad = rad - term;
            else rad = rad + term;
          end
        end
        r = rad;
        q = '0;
        for (int j = 0; j < 61; j++) begin
          r = r << 1;
          q = q << 1;
          if (r >= PI_Q60) begin
            r    = r - PI_Q60;
            q[0] = 1'b1;
          end
        end
        t[i] = q;
      end
    end
    return t;
  endfunction

  localparam atan_arr_t ATAN_TAB = build_atan();

  function automatic logic [63:0] calc_inv_gain();
    longint      gx;
    longint      gy;
    longint      nx;
    longint      ny;
    logic [63:0] z;
    gx = longint'(1) <<< FRAC;
    gy = 0;
    z  = '0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (!z[63]) begin
        nx = gx - (gy >>> i);
        ny = gy + (gx >>> i);
        z  = z - ATAN_TAB[i];
      end else begin
        nx = gx + (gy >>> i);
        ny = gy - (gx >>> i);
        z  = z + ATAN_TAB[i];
      end
      gx = nx;
      gy = ny;
    end
    if (gx <= 0) gx = 1;
    return udiv64(64'((longint'(1) <<< (2 * FRAC)) + (gx >>> 1)), 64'(gx));
  endfunction

  localparam logic signed [IG_W-1:0] INV_GAIN = IG_W'(calc_inv_gain());

  localparam logic [63:0] K_TILT     = turn_frac(64'd313, 64'd1800);
  localparam logic [63:0] K_NODE_EQ  = turn_frac(64'd769, 64'd1440);
  localparam logic [63:0] K_OFF_GAL  = turn_frac(64'd303, 64'd360);
  localparam logic [63:0] K_NODE_GAL = turn_frac(64'd123, 64'd360);
  localparam logic [63:0] K_OFF_EQ   = turn_frac(64'd49, 64'd1440);

  // a * inverse gain, rounded to nearest, FRAC fraction bits
  function automatic logic signed [XW-1:0] mulq(input logic signed [XW-1:0] a);
    logic signed [XW+IG_W-1:0] prod;
    prod = (XW+IG_W)'(a) * (XW+IG_W)'(INV_GAIN);
    prod = prod + (XW+IG_W)'(64'd1 << (FRAC - 1));
    prod = prod >>> FRAC;
    return prod[XW-1:0];
  endfunction

endpackage

>>> rtl/scr_in_if.sv
// Input channel: one sky position and the direction flag.
interface scr_in_if;
  import scr_pkg::*;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [ANGLE_BITS-1:0]        in_lon;
  logic signed [ANGLE_BITS-1:0] in_lat;
  modport source (output valid, output op, output in_lon, output in_lat, input ready);
  modport sink (input valid, input op, input in_lon, input in_lat, output ready);
endinterface

>>> rtl/scr_out_if.sv
// Output channel: the converted position and the pole flag.
interface scr_out_if;
  import scr_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [ANGLE_BITS-1:0]        out_lon;
  logic signed [ANGLE_BITS-1:0] out_lat;
  logic                         at_pole;
  modport source (output valid, output out_lon, output out_lat, output at_pole, input ready);
  modport sink (input valid, input out_lon, input out_lat, input at_pole, output ready);
endinterface

>>> rtl/scr_cell.sv
// One CORDIC micro-rotation cell, rotation or vectoring mode, registered.
module scr_cell import scr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vector_i,
  input  logic [SHIFT_W-1:0] stage_i,
  input  logic [63:0]        atan_i,
  input  logic               valid_i,
  input  vec_t               vec_i,
  output logic               valid_o,
  output vec_t               vec_o
);

  logic                 valid_q;
  vec_t                 vec_q, vec_d;
  logic                 ccw;
  logic signed [XW-1:0] xs, ys;

  always_comb begin
    ccw = vector_i ? vec_i.y[XW-1] : !vec_i.z[63];
    xs  = vec_i.x >>> stage_i;
    ys  = vec_i.y >>> stage_i;
    vec_d = vec_i;
    if (ccw) begin
      vec_d.x = vec_i.x - ys;
      vec_d.y = vec_i.y + xs;
      vec_d.z = vec_i.z - atan_i;
    end else begin
      vec_d.x = vec_i.x + ys;
      vec_d.y = vec_i.y - xs;
      vec_d.z = vec_i.z + atan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

>>> rtl/scr_chain.sv
// Row of CORDIC cells with the quadrant fold in front.
module scr_chain import scr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vector_i,
  input  logic valid_i,
  input  vec_t vec_i,
  output logic valid_o,
  output vec_t vec_o
);

  logic tap_v [CORDIC_STAGES+1];
  vec_t tap   [CORDIC_STAGES+1];

  // fold into the range the micro-rotations converge over
  always_comb begin
    tap[0] = vec_i;
    if (vector_i) begin
      if (vec_i.x[XW-1]) begin
        if (!vec_i.y[XW-1]) begin
          tap[0].x = vec_i.y;
          tap[0].y = -vec_i.x;
          tap[0].z = QUARTER;
        end else begin
          tap[0].x = -vec_i.y;
          tap[0].y = vec_i.x;
          tap[0].z = 64'd0 - QUARTER;
        end
      end
    end else if (vec_i.z[63] ^ vec_i.z[62]) begin
      tap[0].x = -vec_i.x;
      tap[0].y = -vec_i.y;
      tap[0].z = vec_i.z ^ HALF;
    end
  end

  assign tap_v[0] = valid_i;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    scr_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en_i),
      .vector_i (vector_i),
      .stage_i  (SHIFT_W'(g)),
      .atan_i   (ATAN_TAB[g]),
      .valid_i  (tap_v[g]),
      .vec_i    (tap[g]),
      .valid_o  (tap_v[g+1]),
      .vec_o    (tap[g+1])
    );
  end

  assign valid_o = tap_v[CORDIC_STAGES];
  assign vec_o   = tap[CORDIC_STAGES];

endmodule

>>> rtl/sky_coordinate_rotation.sv
// Top level: B1950 equatorial <-> galactic rotation as five chained CORDIC rows.
// Throughput: one position per cycle while the skid register is empty.
// Every CORDIC row is fully pipelined, one cell per step.
// An output register plus a skid register hold results, so input stalls only when both are full.
// Reset (asynchronous, active low) clears all valid bits; no state survives between items.
module sky_coordinate_rotation import scr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  scr_in_if.sink    in_i,
  scr_out_if.source out_o
);

  logic en;
  logic skid_v_q, out_v_q;
  res_t skid_q, out_q, res;

  assign en       = !skid_v_q;
  assign in_i.ready = en;

  // ---- row 1: (inv_gain, 0) rotated by latitude
  logic [63:0] lon64, lat64, u_in;
  logic        pole_in;
  logic        c0_v;
  vec_t        c0;

  always_comb begin
    lon64   = {in_i.in_lon, SHIFT'(0)};
    lat64   = {in_i.in_lat, SHIFT'(0)};
    pole_in = (lat64 == QUARTER) || (lat64 == (64'd0 - QUARTER));
    u_in    = in_i.op ? (lon64 - K_NODE_GAL) : (K_NODE_EQ - lon64);
    c0.x          = XW'(INV_GAIN);
    c0.y          = '0;
    c0.z          = lat64;
    c0.side.op    = in_i.op;
    c0.side.pole  = pole_in;
    c0.side.north = (lat64 == QUARTER);
    c0.side.off   = in_i.op ? K_OFF_EQ : K_OFF_GAL;
    c0.side.aux_a = u_in;
    c0.side.aux_v = '0;
    c0_v          = in_i.valid;
  end

  logic c1_v;
  vec_t c1;
  scr_chain u_row_lat (
    .clk_i, .rst_ni, .en_i(en), .vector_i(1'b0),
    .valid_i(c0_v), .vec_i(c0), .valid_o(c1_v), .vec_o(c1)
  );

  // ---- pole override, p = cos(lat) scaled
  logic                 m1_v_q;
  vec_t                 m1_q, m1_d;
  logic signed [XW-1:0] cd, sd;

  always_comb begin
    cd = c1.side.pole ? '0 : c1.x;
    sd = c1.side.pole ? (c1.side.north ? ONE : -ONE) : c1.y;
    m1_d            = c1;
    m1_d.x          = mulq(cd);
    m1_d.y          = '0;
    m1_d.z          = c1.side.aux_a;
    m1_d.side.aux_v = sd;
  end

  // ---- row 2: (p, 0) rotated by u -> (p, q)
  logic c2_v;
  vec_t c2;
  scr_chain u_row_node (
    .clk_i, .rst_ni, .en_i(en), .vector_i(1'b0),
    .valid_i(m1_v_q), .vec_i(m1_q), .valid_o(c2_v), .vec_o(c2)
  );

  logic m2_v_q;
  vec_t m2_q, m2_d;

  always_comb begin
    m2_d            = c2;
    m2_d.x          = mulq(c2.x);
    m2_d.y          = mulq(c2.side.aux_v);
    m2_d.z          = K_TILT;
    m2_d.side.aux_v = c2.y;
  end

  // ---- row 3: (p, sin lat) rotated by the pole tilt -> (D, Z)
  logic c3_v;
  vec_t c3;
  scr_chain u_row_tilt (
    .clk_i, .rst_ni, .en_i(en), .vector_i(1'b0),
    .valid_i(m2_v_q), .vec_i(m2_q), .valid_o(c3_v), .vec_o(c3)
  );

  // ---- row 4: atan2(q, D)
  vec_t c3f;
  always_comb begin
    c3f            = c3;
    c3f.y          = c3.side.aux_v;
    c3f.z          = '0;
    c3f.side.aux_v = c3.y;
  end

  logic c4_v;
  vec_t c4;
  scr_chain u_row_lon (
    .clk_i, .rst_ni, .en_i(en), .vector_i(1'b1),
    .valid_i(c3_v), .vec_i(c3f), .valid_o(c4_v), .vec_o(c4)
  );

  logic m3_v_q;
  vec_t m3_q, m3_d;

  always_comb begin
    m3_d            = c4;
    m3_d.x          = mulq(c4.x);
    m3_d.y          = c4.side.aux_v;
    m3_d.z          = '0;
    m3_d.side.aux_a = c4.side.pole ? (c4.side.north ? HALF : 64'd0) : c4.z;
  end

  // ---- row 5: asin(Z) as atan2(Z, r)
  logic c5_v;
  vec_t c5;
  scr_chain u_row_lat_out (
    .clk_i, .rst_ni, .en_i(en), .vector_i(1'b1),
    .valid_i(m3_v_q), .vec_i(m3_q), .valid_o(c5_v), .vec_o(c5)
  );

  // ---- rounding and clamping
  logic [63:0]        outa, lon_r;
  logic signed [63:0] b, bs;
  localparam logic signed [63:0] QLIM = 64'sd1 <<< (ANGLE_BITS - 2);

  always_comb begin
    outa  = c5.side.op ? (c5.side.off + c5.side.aux_a) : (c5.side.off - c5.side.aux_a);
    lon_r = (outa + (64'd1 << (SHIFT - 1))) >> SHIFT;
    b     = $signed(c5.z);
    if (b > $signed(QUARTER)) b = $signed(QUARTER);
    if (b < -$signed(QUARTER)) b = -$signed(QUARTER);
    bs = (b + (64'sd1 <<< (SHIFT - 1))) >>> SHIFT;
    if (bs > QLIM) bs = QLIM;
    if (bs < -QLIM) bs = -QLIM;
    res.at_pole = c5.side.pole;
    res.out_lon = lon_r[ANGLE_BITS-1:0];
    res.out_lat = bs[ANGLE_BITS-1:0];
  end

  // ---- mid-pipe registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      m3_v_q <= 1'b0;
    end else if (en) begin
      m1_v_q <= c1_v;
      m2_v_q <= c2_v;
      m3_v_q <= c4_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q <= m1_d;
      m2_q <= m2_d;
      m3_q <= m3_d;
    end
  end

  // ---- output register with skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_o.ready || !out_v_q) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= c5_v;
      end
    end else if (c5_v && en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_o.ready || !out_v_q) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (c5_v && en) begin
      skid_q <= res;
    end
  end

  assign out_o.valid   = out_v_q;
  assign out_o.out_lon = out_q.out_lon;
  assign out_o.out_lat = out_q.out_lat;
  assign out_o.at_pole = out_q.at_pole;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid holds data while output is empty");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_o.ready))
    else $error("skid loaded while output was free");

  a_lat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> ($signed(out_q.out_lat) <= $signed(QLIM[ANGLE_BITS-1:0])
                 && $signed(out_q.out_lat) >= -$signed(QLIM[ANGLE_BITS-1:0])))
    else $error("output latitude beyond a quarter turn");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the B1950 equatorial/galactic sky coordinate rotation.
`timescale 1ns / 1ps
module tb_top import scr_pkg::*;;

  logic clk_i;
  logic rst_ni;

  scr_in_if  in_if ();
  scr_out_if out_if ();

  sky_coordinate_rotation dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  localparam logic [63:0] QTURN = 64'h4000_0000_0000_0000;
  localparam logic [63:0] HTURN = 64'h8000_0000_0000_0000;
  localparam int          NSTG  = CORDIC_STAGES;
  localparam int          PIPE_LAT = 5 * NSTG + 4;

  typedef enum logic { EQ_TO_GAL = 1'b0, GAL_TO_EQ = 1'b1 } dir_e;

  typedef struct {
    dir_e        dir;
    logic [31:0] lon;
    logic [31:0] lat;
    bit          pole_known;
    logic        pole;
  } stim_row_t;

  logic [63:0] arctan_q64 [NSTG];
  longint      gain_corr;
  logic [63:0] tilt_ang, node_eq, off_gal, node_gal, off_eq;

  res_t        sky_expect_q [$];
  int          mismatches;
  int          tx_idle_pct, rx_idle_pct;
  bit          hold_req;
  int          hold_cnt;

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  initial begin
    #5_000_000;
    $display("sky_coordinate_rotation verification failed");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic logic [63:0] frac_of_turn(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] r, q;
    r = n;
    q = '0;
    for (int j = 0; j < 64; j++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    if ((r << 1) >= d) q = q + 1;
    return q;
  endfunction

  function automatic void cordic_rot(inout longint x, inout longint y, input logic [63:0] a);
    logic [63:0] z, t;
    longint      nx, ny;
    z = a;
    t = a + QTURN;
    if (t[63]) begin
      x = -x;
      y = -y;
      z = a + HTURN;
    end
    for (int i = 0; i < NSTG; i++) begin
      if (!z[63]) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - arctan_q64[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + arctan_q64[i];
      end
      x = nx;
      y = ny;
    end
  endfunction

  function automatic logic [63:0] cordic_vec(input longint x, input longint y, output longint mag);
    logic [63:0] z;
    longint      t, nx, ny;
    z = '0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = QTURN;
      end else begin
        x = -y; y = t; z = -QTURN;
      end
    end
    for (int i = 0; i < NSTG; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + arctan_q64[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - arctan_q64[i];
      end
      x = nx;
      y = ny;
    end
    mag = x;
    return z;
  endfunction

  function automatic longint gain_fix(input longint a);
    return (a * gain_corr + (longint'(1) <<< 29)) >>> 30;
  endfunction

  function automatic void init_constants();
    logic [63:0] rad, r, q, term;
    longint      gx, gy;
    int          e;
    arctan_q64[0] = 64'd1 << 61;
    for (int i = 1; i < NSTG; i++) begin
      rad = '0;
      for (int k = 0; 62 - i * (2 * k + 1) >= 0; k++) begin
        e = 62 - i * (2 * k + 1);
        term = (64'd1 << e) / 64'(2 * k + 1);
        if (k % 2) rad = rad - term;
        else rad = rad + term;
      end
      r = rad;
      q = '0;
      for (int j = 0; j < 61; j++) begin
        r = r << 1;
        q = q << 1;
        if (r >= 64'h3243_F6A8_885A_308D) begin
          r = r - 64'h3243_F6A8_885A_308D;
          q[0] = 1'b1;
        end
      end
      arctan_q64[i] = q;
    end
    tilt_ang = frac_of_turn(313, 1800);
    node_eq  = frac_of_turn(769, 1440);
    off_gal  = frac_of_turn(303, 360);
    node_gal = frac_of_turn(123, 360);
    off_eq   = frac_of_turn(49, 1440);
    gx = longint'(1) <<< 30;
    gy = 0;
    cordic_rot(gx, gy, '0);
    if (gx <= 0) gx = 1;
    gain_corr = ((longint'(1) <<< 60) + gx / 2) / gx;
  endfunction

  function automatic res_t rotate_sky(input dir_e dir, input logic [31:0] lon,
                                      input logic [31:0] lat);
    res_t        res;
    logic [63:0] lon64, lat64, u, off, turn, outa, sum;
    longint      cd, sd, p, q, d, zz, mag, r, b, bs;
    bit          pole;
    lon64 = {lon, 32'd0};
    lat64 = {lat, 32'd0};
    pole  = (lat64 == QTURN) || (lat64 == -QTURN);
    if (dir == EQ_TO_GAL) begin
      u = node_eq - lon64; off = off_gal;
    end else begin
      u = lon64 - node_gal; off = off_eq;
    end
    if (pole) begin
      cd = 0;
      sd = (lat64 == QTURN) ? (longint'(1) <<< 30) : -(longint'(1) <<< 30);
    end else begin
      cd = gain_corr;
      sd = 0;
      cordic_rot(cd, sd, lat64);
    end
    p = gain_fix(cd);
    q = 0;
    cordic_rot(p, q, u);
    d  = gain_fix(p);
    zz = gain_fix(sd);
    cordic_rot(d, zz, tilt_ang);
    turn = cordic_vec(d, q, mag);
    if (pole) turn = (lat64 == QTURN) ? HTURN : '0;
    r = gain_fix(mag);
    b = longint'(cordic_vec(r, zz, mag));
    outa = (dir == EQ_TO_GAL) ? off - turn : off + turn;
    sum  = outa + 64'h8000_0000;
    if (b > longint'(QTURN)) b = longint'(QTURN);
    if (b < -longint'(QTURN)) b = -longint'(QTURN);
    bs = (b + (longint'(1) <<< 31)) >>> 32;
    if (bs > (longint'(1) <<< 30)) bs = longint'(1) <<< 30;
    if (bs < -(longint'(1) <<< 30)) bs = -(longint'(1) <<< 30);
    res.out_lon = sum[63:32];
    res.out_lat = bs[31:0];
    res.at_pole = pole;
    return res;
  endfunction

  // ---------------- sender ----------------
  task automatic send_pos(input stim_row_t row);
    res_t exp_res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.op     <= row.dir;
    in_if.in_lon <= row.lon;
    in_if.in_lat <= row.lat;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    exp_res = rotate_sky(row.dir, row.lon, row.lat);
    if (row.pole_known) exp_res.at_pole = row.pole;
    sky_expect_q.push_back(exp_res);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (sky_expect_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic stim_row_t random_pos();
    stim_row_t row;
    int        pick;
    row.dir = dir_e'($urandom_range(1));
    row.lon = $urandom();
    row.pole_known = 1'b0;
    row.pole = 1'b0;
    pick = $urandom_range(99);
    if (pick < 80) row.lat = 32'($signed($urandom_range(32'h7FFF_FFFE)) - 32'sh3FFF_FFFF);
    else if (pick < 90) row.lat = $urandom();
    else row.lat = ($urandom_range(1) ? 32'h4000_0000 : 32'hC000_0000)
                   + 32'($signed($urandom_range(4)) - 2);
    return row;
  endfunction

  stim_row_t directed [] = '{
    '{EQ_TO_GAL, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0},
    '{GAL_TO_EQ, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0},
    '{EQ_TO_GAL, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0},
    '{GAL_TO_EQ, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0},
    '{EQ_TO_GAL, 32'h1234_5678, 32'h4000_0000, 1'b1, 1'b1},  // north pole
    '{EQ_TO_GAL, 32'h8765_4321, 32'hC000_0000, 1'b1, 1'b1},  // south pole
    '{GAL_TO_EQ, 32'hFFFF_FFFF, 32'h4000_0000, 1'b1, 1'b1},
    '{GAL_TO_EQ, 32'h0000_0000, 32'hC000_0000, 1'b1, 1'b1},
    '{EQ_TO_GAL, 32'h8000_0000, 32'h3FFF_FFFF, 1'b1, 1'b0},
    '{EQ_TO_GAL, 32'h4000_0000, 32'hC000_0001, 1'b1, 1'b0},
    '{GAL_TO_EQ, 32'hC000_0000, 32'h3FFF_FFFF, 1'b1, 1'b0},
    '{GAL_TO_EQ, 32'h7FFF_FFFF, 32'hC000_0001, 1'b1, 1'b0},
    // past the pole
    '{EQ_TO_GAL, 32'h2000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0},
    '{EQ_TO_GAL, 32'hA000_0000, 32'h8000_0000, 1'b1, 1'b0},
    '{GAL_TO_EQ, 32'h5555_5555, 32'h4000_0001, 1'b1, 1'b0},
    '{GAL_TO_EQ, 32'hAAAA_AAAA, 32'hBFFF_FFFF, 1'b1, 1'b0},
    // near the galactic poles seen from equatorial, then two galactic-to-equatorial rows
    '{EQ_TO_GAL, 32'd2293631841, 32'd326894733, 1'b0, 1'b0},
    '{EQ_TO_GAL, 32'd146148193, -32'd326894733, 1'b0, 1'b0},
    '{GAL_TO_EQ, 32'd0, 32'd326894733, 1'b0, 1'b0},
    '{GAL_TO_EQ, 32'hFFFF_0000, 32'hF0F0_F0F0, 1'b0, 1'b0}
  };

  initial begin
    in_if.valid  = 1'b0;
    in_if.op     = 1'b0;
    in_if.in_lon = '0;
    in_if.in_lat = '0;
    out_if.ready = 1'b0;
    hold_req     = 1'b0;
    mismatches   = 0;
    tx_idle_pct  = 13;
    rx_idle_pct  = 72;
    init_constants();
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_pos(directed[i]);
    repeat (210) send_pos(random_pos());
    drain_results();  // sender pause until every result is back

    tx_idle_pct = 72;
    rx_idle_pct = 13;
    repeat (210) send_pos(random_pos());
    drain_results();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;  // long receiver hold-off so the pipe fills and backs up
    repeat (230) send_pos(random_pos());
    in_if.valid <= 1'b0;

    fork
      while (sky_expect_q.size() != 0) @(posedge clk_i);
      repeat (20000) @(posedge clk_i);
    join_any
    disable fork;
    repeat (PIPE_LAT + 20) @(posedge clk_i);

    if (mismatches == 0 && sky_expect_q.size() == 0) begin
      $display("sky_coordinate_rotation verification clean");
    end else begin
      $display("sky_coordinate_rotation verification failed");
    end
    $finish;
  end

  // ---------------- receiver ----------------
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial hold_cnt = 0;

  always @(posedge clk_i) begin
    res_t exp_res;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (sky_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: lon %h lat %h pole %b",
                                       out_if.out_lon, out_if.out_lat, out_if.at_pole);
      end else begin
        exp_res = sky_expect_q.pop_front();
        if (out_if.out_lon !== exp_res.out_lon || out_if.out_lat !== exp_res.out_lat ||
            out_if.at_pole !== exp_res.at_pole) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: lon exp %h got %h, lat exp %h got %h, pole exp %b got %b",
                     exp_res.out_lon, out_if.out_lon, exp_res.out_lat, out_if.out_lat,
                     exp_res.at_pole, out_if.at_pole);
        end
      end
    end
  end

endmodule
